[src/pcaw_pkg.sv]
// Shared types and constants for the PID controller with clamp anti-windup.
// Used by pcaw_cfg, pcaw_mul and pid_controller_clamp_antiwindup.
// No dependencies.
package pcaw_pkg;

    // Field and datapath widths
    localparam int DATA_W  = 16;
    localparam int ERR_W   = DATA_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int INTEG_W = 48;
    localparam int DERIV_W = 34;
    localparam int MUL_W   = 18;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 52;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE = 3'd6;

    // Reset values and substitutes for a zero period
    localparam logic [DATA_W-1:0] STEP_TIME_DEFAULT = 16'd66;
    localparam logic [DATA_W-1:0] STEP_RATE_DEFAULT = 16'd1000;
    localparam logic [DATA_W-1:0] DRIVE_MIN_RESET   = 16'h8000;
    localparam logic [DATA_W-1:0] DRIVE_MAX_RESET   = 16'h7FFF;

    // Saturation limits of the integral
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Current register contents; the periods already have zero replaced
    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic signed [DATA_W-1:0] drive_min;
        logic signed [DATA_W-1:0] drive_max;
        logic [DATA_W-1:0]        step_time;
        logic [DATA_W-1:0]        step_rate;
    } cfg_t;

    // Sequencer steps: each ST_MUL_* step issues one product to the shared multiplier
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_P,
        ST_MUL_I0,
        ST_MUL_I1,
        ST_MUL_I2,
        ST_MUL_D0,
        ST_MUL_D1,
        ST_SUM,
        ST_CLAMP,
        ST_FINISH
    } state_t;

endpackage

[src/pcaw_cfg.sv]
// Configuration register file of the PID controller.
// Depends on pcaw_pkg for the register indexes, reset values and cfg_t.
module pcaw_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcaw_pkg::DATA_W-1:0]     cfg_data,
    output pcaw_pkg::cfg_t                  cfg
);

    logic [pcaw_pkg::DATA_W-1:0] gain_p_reg;
    logic [pcaw_pkg::DATA_W-1:0] gain_i_reg;
    logic [pcaw_pkg::DATA_W-1:0] gain_d_reg;
    logic [pcaw_pkg::DATA_W-1:0] drive_min_reg;
    logic [pcaw_pkg::DATA_W-1:0] drive_max_reg;
    logic [pcaw_pkg::DATA_W-1:0] step_time_reg;
    logic [pcaw_pkg::DATA_W-1:0] step_rate_reg;

    // Register writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            drive_min_reg <= pcaw_pkg::DRIVE_MIN_RESET;
            drive_max_reg <= pcaw_pkg::DRIVE_MAX_RESET;
            step_time_reg <= pcaw_pkg::STEP_TIME_DEFAULT;
            step_rate_reg <= pcaw_pkg::STEP_RATE_DEFAULT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcaw_pkg::REG_GAIN_P:    gain_p_reg    <= cfg_data;
                pcaw_pkg::REG_GAIN_I:    gain_i_reg    <= cfg_data;
                pcaw_pkg::REG_GAIN_D:    gain_d_reg    <= cfg_data;
                pcaw_pkg::REG_DRIVE_MIN: drive_min_reg <= cfg_data;
                pcaw_pkg::REG_DRIVE_MAX: drive_max_reg <= cfg_data;
                pcaw_pkg::REG_STEP_TIME: step_time_reg <= cfg_data;
                pcaw_pkg::REG_STEP_RATE: step_rate_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A zero period stands for the one-millisecond default.
    always_comb
    begin
        cfg.gain_p    = gain_p_reg;
        cfg.gain_i    = gain_i_reg;
        cfg.gain_d    = gain_d_reg;
        cfg.drive_min = drive_min_reg;
        cfg.drive_max = drive_max_reg;
        cfg.step_time = (step_time_reg == '0) ? pcaw_pkg::STEP_TIME_DEFAULT : step_time_reg;
        cfg.step_rate = (step_rate_reg == '0) ? pcaw_pkg::STEP_RATE_DEFAULT : step_rate_reg;
    end

endmodule

[src/pcaw_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on pcaw_pkg for the operand and product widths.
module pcaw_mul
(
    input  logic                                clk,
    input  logic signed [pcaw_pkg::MUL_W-1:0]   op_a,
    input  logic signed [pcaw_pkg::MUL_W-1:0]   op_b,
    output logic signed [pcaw_pkg::PROD_W-1:0]  prod
);

    logic signed [pcaw_pkg::PROD_W-1:0] prod_reg;

    // One product per cycle, registered before any further use.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

[src/pid_controller_clamp_antiwindup.sv]
// PID controller with clamp-based anti-windup: one result per transfer of a
// target and sample. An item is taken only while the block is idle, so a new
// sample is not taken before the result of the last one has been loaded into
// the output register. Each item runs through the eight products that all
// pass, one per cycle, through the single 18x18 multiplier,
// plus a step that adds the last registered product, a clamp step and the
// output load.
// A finished result waits in the output register while drive is stalled;
// the block holds its last step until that register is free.
// Depends on pcaw_pkg, pcaw_cfg and pcaw_mul.
module pid_controller_clamp_antiwindup
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcaw_pkg::DATA_W-1:0]         cfg_data,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pcaw_pkg::DATA_W-1:0]  target,
    input  logic signed [pcaw_pkg::DATA_W-1:0]  sample,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pcaw_pkg::DATA_W-1:0]  drive,
    output logic                                hit_high,
    output logic                                hit_low
);

    localparam int DW = pcaw_pkg::DATA_W;
    localparam int MW = pcaw_pkg::MUL_W;
    localparam int SW = pcaw_pkg::SUM_W;
    localparam int IW = pcaw_pkg::INTEG_W;
    localparam int LIMB_W = 16;
    localparam int DLO_W = pcaw_pkg::DERIV_W / 2;

    pcaw_pkg::cfg_t   cfg;
    pcaw_pkg::state_t state_reg, state_next;

    logic signed [pcaw_pkg::ERR_W-1:0]   err_reg, err_next;
    logic signed [pcaw_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [pcaw_pkg::ERR_W-1:0]   last_err_reg, last_err_next;
    logic                                first_reg, first_next;
    logic signed [IW-1:0]                acc_reg, acc_next;
    logic signed [IW-1:0]                integ_reg, integ_next;
    logic signed [pcaw_pkg::DERIV_W-1:0] deriv_reg, deriv_next;
    logic signed [SW-1:0]                sum_reg, sum_next;
    logic                                sat_hi_reg, sat_hi_next;
    logic                                sat_lo_reg, sat_lo_next;
    logic signed [DW-1:0]                val_reg, val_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [DW-1:0]                drive_reg, drive_next;
    logic                                hit_high_reg, hit_high_next;
    logic                                hit_low_reg, hit_low_next;

    logic signed [MW-1:0]                op_a;
    logic signed [MW-1:0]                op_b;
    logic signed [pcaw_pkg::PROD_W-1:0]  prod;
    logic signed [SW-1:0]                prod_ext;
    logic signed [IW:0]                  integ_sum;
    logic signed [SW-1:0]                lim_hi;
    logic signed [SW-1:0]                lim_lo;
    logic signed [SW-1:0]                rounded;
    logic                                err_pos;
    logic                                err_neg;
    logic                                out_free;
    logic                                in_xfer;

    pcaw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcaw_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign in_stall  = (state_reg != pcaw_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign hit_high  = hit_high_reg;
    assign hit_low   = hit_low_reg;

    // Shared helpers: the extended product, the integral sum and the limits.
    assign prod_ext  = SW'(prod);
    assign integ_sum = (IW + 1)'(acc_reg) + (IW + 1)'(prod);
    assign lim_hi    = SW'(cfg.drive_max) <<< 8;
    assign lim_lo    = SW'(cfg.drive_min) <<< 8;
    assign rounded   = sum_reg + SW'(128);
    assign err_pos   = !err_reg[pcaw_pkg::ERR_W-1] && (err_reg != '0);
    assign err_neg   = err_reg[pcaw_pkg::ERR_W-1];

    // Multiplier operands for the product issued in each step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            pcaw_pkg::ST_MUL_I:
            begin
                op_a = MW'(err_reg);
                op_b = MW'({1'b0, cfg.step_time});
            end
            pcaw_pkg::ST_MUL_D:
            begin
                op_a = first_reg ? '0 : MW'(diff_reg);
                op_b = MW'({1'b0, cfg.step_rate});
            end
            pcaw_pkg::ST_MUL_P:
            begin
                op_a = MW'(err_reg);
                op_b = MW'(cfg.gain_p);
            end
            pcaw_pkg::ST_MUL_I0:
            begin
                op_a = MW'({1'b0, integ_reg[LIMB_W-1:0]});
                op_b = MW'(cfg.gain_i);
            end
            pcaw_pkg::ST_MUL_I1:
            begin
                op_a = MW'({1'b0, integ_reg[2*LIMB_W-1:LIMB_W]});
                op_b = MW'(cfg.gain_i);
            end
            pcaw_pkg::ST_MUL_I2:
            begin
                op_a = MW'($signed(integ_reg[IW-1:2*LIMB_W]));
                op_b = MW'(cfg.gain_i);
            end
            pcaw_pkg::ST_MUL_D0:
            begin
                op_a = MW'({1'b0, deriv_reg[DLO_W-1:0]});
                op_b = MW'(cfg.gain_d);
            end
            pcaw_pkg::ST_MUL_D1:
            begin
                op_a = MW'($signed(deriv_reg[pcaw_pkg::DERIV_W-1:DLO_W]));
                op_b = MW'(cfg.gain_d);
            end
            default: ;
        endcase
    end

    // Sequencer: each step from ST_MUL_D to ST_SUM consumes the product issued by the step before.
    always_comb
    begin
        state_next     = state_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        last_err_next  = last_err_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        integ_next     = integ_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        sat_hi_next    = sat_hi_reg;
        sat_lo_next    = sat_lo_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg;
        drive_next     = drive_reg;
        hit_high_next  = hit_high_reg;
        hit_low_next   = hit_low_reg;

        // The downstream side takes the waiting result.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            pcaw_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next   = pcaw_pkg::ERR_W'(target) - pcaw_pkg::ERR_W'(sample);
                    diff_next  = pcaw_pkg::DIFF_W'(err_next)
                               - pcaw_pkg::DIFF_W'(last_err_reg);
                    state_next = pcaw_pkg::ST_MUL_I;
                end
            end
            pcaw_pkg::ST_MUL_I:
            begin
                state_next = pcaw_pkg::ST_MUL_D;
            end
            pcaw_pkg::ST_MUL_D:
            begin
                // Tentative integral, saturated to 48 bits.
                if (integ_sum[IW] != integ_sum[IW-1])
                begin
                    integ_next = integ_sum[IW] ? pcaw_pkg::INTEG_MIN : pcaw_pkg::INTEG_MAX;
                end
                else
                begin
                    integ_next = integ_sum[IW-1:0];
                end
                state_next = pcaw_pkg::ST_MUL_P;
            end
            pcaw_pkg::ST_MUL_P:
            begin
                deriv_next = prod[pcaw_pkg::DERIV_W-1:0];
                state_next = pcaw_pkg::ST_MUL_I0;
            end
            pcaw_pkg::ST_MUL_I0:
            begin
                // Proportional term starts the sum.
                sum_next   = prod_ext;
                state_next = pcaw_pkg::ST_MUL_I1;
            end
            pcaw_pkg::ST_MUL_I1:
            begin
                // Low limb of the integral product, floored to Q.8.
                sum_next   = sum_reg + (prod_ext >>> LIMB_W);
                state_next = pcaw_pkg::ST_MUL_I2;
            end
            pcaw_pkg::ST_MUL_I2:
            begin
                sum_next   = sum_reg + prod_ext;
                state_next = pcaw_pkg::ST_MUL_D0;
            end
            pcaw_pkg::ST_MUL_D0:
            begin
                sum_next   = sum_reg + (prod_ext <<< LIMB_W);
                state_next = pcaw_pkg::ST_MUL_D1;
            end
            pcaw_pkg::ST_MUL_D1:
            begin
                sum_next   = sum_reg + prod_ext;
                state_next = pcaw_pkg::ST_SUM;
            end
            pcaw_pkg::ST_SUM:
            begin
                sum_next   = sum_reg + (prod_ext <<< DLO_W);
                state_next = pcaw_pkg::ST_CLAMP;
            end
            pcaw_pkg::ST_CLAMP:
            begin
                // Clamp with the high limit winning, then the windup decision.
                sat_hi_next = sum_reg > lim_hi;
                sat_lo_next = sum_reg < lim_lo;
                if (sat_hi_next)
                begin
                    val_next = cfg.drive_max;
                end
                else if (sat_lo_next)
                begin
                    val_next = cfg.drive_min;
                end
                else
                begin
                    val_next = rounded[DW+7:8];
                end
                if (!((sat_hi_next && err_pos) || (sat_lo_next && err_neg)))
                begin
                    acc_next = integ_reg;
                end
                last_err_next = err_reg;
                first_next    = 1'b0;
                state_next    = pcaw_pkg::ST_FINISH;
            end
            pcaw_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    drive_next     = val_reg;
                    hit_high_next  = sat_hi_reg;
                    hit_low_next   = sat_lo_reg;
                    state_next     = pcaw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pcaw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and controller history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcaw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            last_err_reg  <= '0;
            first_reg     <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            last_err_reg  <= last_err_next;
            first_reg     <= first_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        diff_reg     <= diff_next;
        integ_reg    <= integ_next;
        deriv_reg    <= deriv_next;
        sum_reg      <= sum_next;
        sat_hi_reg   <= sat_hi_next;
        sat_lo_reg   <= sat_lo_next;
        val_reg      <= val_next;
        drive_reg    <= drive_next;
        hit_high_reg <= hit_high_next;
        hit_low_reg  <= hit_low_next;
    end

endmodule

[tb/pcaw_checker.sv]
`timescale 1ns / 1ps
// Result checker for pid_controller_clamp_antiwindup: it watches both channels and the
// register port, predicts each result and compares it with what the block delivers.
// Depends on pcaw_pkg.
module pcaw_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pcaw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcaw_pkg::DATA_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [pcaw_pkg::DATA_W-1:0]  target,
    input  logic signed [pcaw_pkg::DATA_W-1:0]  sample,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [pcaw_pkg::DATA_W-1:0]  drive,
    input  logic                                hit_high,
    input  logic                                hit_low,
    output int                                  fail_count,
    output int                                  backlog,
    output int                                  results_seen
);

    import pcaw_pkg::*;

    // One predicted controller output
    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     hit_high;
        logic                     hit_low;
    } control_out_t;

    localparam longint ACC_TOP    = INTEG_MAX;
    localparam longint ACC_BOTTOM = INTEG_MIN;

    // Shadow copy of the registers
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] lim_lo;
    logic signed [DATA_W-1:0] lim_hi;
    logic [DATA_W-1:0]        period;
    logic [DATA_W-1:0]        rate_hz;

    // Controller state: integral in Q32.16, previous error, derivative armed
    longint integ_acc;
    longint prev_err;
    bit     primed;

    control_out_t pending_drive_q[$];
    control_out_t head;
    int           bad_count;
    int           seen_count;

    // Advance the controller by one sample and return the clamped output.
    function automatic control_out_t pid_step(input logic signed [DATA_W-1:0] tgt,
                                              input logic signed [DATA_W-1:0] meas);
        longint       err;
        longint       dt;
        longint       rate;
        longint       deriv;
        longint       integ;
        longint       u;
        longint       ceil_hi;
        longint       floor_lo;
        longint       rounded;
        bit           sat_hi;
        bit           sat_lo;
        control_out_t res;

        err  = longint'(tgt) - longint'(meas);
        dt   = (period == '0) ? longint'(STEP_TIME_DEFAULT) : longint'(period);
        rate = (rate_hz == '0) ? longint'(STEP_RATE_DEFAULT) : longint'(rate_hz);
        deriv = primed ? (err - prev_err) * rate : 64'sd0;

        // Tentative integral, held inside the signed 48-bit range
        integ = integ_acc + err * dt;
        if (integ > ACC_TOP)
            integ = ACC_TOP;
        else if (integ < ACC_BOTTOM)
            integ = ACC_BOTTOM;

        // Sum in Q.8; the integral term is floored from Q.24
        u = longint'(kp) * err + ((longint'(ki) * integ) >>> 16) + longint'(kd) * deriv;

        ceil_hi  = longint'(lim_hi) * 256;
        floor_lo = longint'(lim_lo) * 256;
        sat_hi   = (u > ceil_hi);
        sat_lo   = (u < floor_lo);

        // The high limit wins when the limits are crossed
        rounded = (u + 128) >>> 8;
        if (sat_hi)
            res.drive = lim_hi;
        else if (sat_lo)
            res.drive = lim_lo;
        else
            res.drive = rounded[DATA_W-1:0];
        res.hit_high = sat_hi;
        res.hit_low  = sat_lo;

        // Conditional integration: hold the integral while pushing into a limit
        if (!((sat_hi && err > 0) || (sat_lo && err < 0)))
            integ_acc = integ;
        prev_err = err;
        primed   = 1'b1;
        return res;
    endfunction

    // Register writes, transfers in, results out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp        = '0;
            ki        = '0;
            kd        = '0;
            lim_lo    = DRIVE_MIN_RESET;
            lim_hi    = DRIVE_MAX_RESET;
            period    = STEP_TIME_DEFAULT;
            rate_hz   = STEP_RATE_DEFAULT;
            integ_acc = 0;
            prev_err  = 0;
            primed    = 1'b0;
            pending_drive_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_P:    kp = cfg_data;
                    REG_GAIN_I:    ki = cfg_data;
                    REG_GAIN_D:    kd = cfg_data;
                    REG_DRIVE_MIN: lim_lo = cfg_data;
                    REG_DRIVE_MAX: lim_hi = cfg_data;
                    REG_STEP_TIME: period = cfg_data;
                    REG_STEP_RATE: rate_hz = cfg_data;
                    default: ;
                endcase
            end

            // Compare a delivered result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen_count++;
                if (pending_drive_q.size() == 0)
                begin
                    bad_count++;
                    $display("%0t: result transfer with none expected: drive %0d", $time, drive);
                end
                else
                begin
                    head = pending_drive_q.pop_front();
                    if (head.drive !== drive)
                    begin
                        bad_count++;
                        $display("%0t: drive expected %0d, got %0d", $time, head.drive, drive);
                    end
                    if (head.hit_high !== hit_high)
                    begin
                        bad_count++;
                        $display("%0t: hit_high expected %0b, got %0b",
                                 $time, head.hit_high, hit_high);
                    end
                    if (head.hit_low !== hit_low)
                    begin
                        bad_count++;
                        $display("%0t: hit_low expected %0b, got %0b",
                                 $time, head.hit_low, hit_low);
                    end
                end
            end

            if (in_valid && !in_stall)
                pending_drive_q.push_back(pid_step(target, sample));
        end
        fail_count   <= bad_count;
        backlog      <= pending_drive_q.size();
        results_seen <= seen_count;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Top of the testbench for pid_controller_clamp_antiwindup: clock, reset, register
// writes, sample stimulus with idle gaps and output stalls, and the final verdict.
// Depends on pcaw_pkg, the block itself and pcaw_checker.
module tb;

    import pcaw_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int WINDUP_ITEMS = 40;
    localparam int PHASE_ITEMS  = 230;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] target = '0;
    logic signed [DATA_W-1:0] sample = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] drive;
    logic                     hit_high;
    logic                     hit_low;

    int fail_count;
    int backlog;
    int results_seen;
    int n_items = 0;
    int n_settings = 0;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;
    logic signed [DATA_W-1:0] setpoint = '0;

    pid_controller_clamp_antiwindup i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .hit_high  (hit_high),
        .hit_low   (hit_low)
    );

    pcaw_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target       (target),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive        (drive),
        .hit_high     (hit_high),
        .hit_low      (hit_low),
        .fail_count   (fail_count),
        .backlog      (backlog),
        .results_seen (results_seen)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    // Output side: stall in segments of random density, with long hold-offs
    initial
    begin
        int seg_left;
        int stall_pct;
        bit hold_taken;
        seg_left   = 0;
        stall_pct  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((hold_req && !hold_taken) || $urandom_range(0, 4999) == 0)
            begin
                hold_taken = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 80);
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 20;
                    3: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            seg_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // One register write; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Offer one sample and hold it until the block takes it.
    task automatic send_item(input logic signed [DATA_W-1:0] t,
                             input logic signed [DATA_W-1:0] s);
        in_valid <= 1'b1;
        target   <= t;
        sample   <= s;
        do
            @(posedge clk);
        while (in_stall);
        n_items++;
    endtask

    task automatic idle_for(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has been delivered.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
        repeat (2) @(posedge clk);
    endtask

    // Rewrite every register while idle, plus a write to an unused index.
    task automatic set_config(input logic signed [DATA_W-1:0] gp,
                              input logic signed [DATA_W-1:0] gi,
                              input logic signed [DATA_W-1:0] gd,
                              input logic signed [DATA_W-1:0] lo,
                              input logic signed [DATA_W-1:0] hi,
                              input logic [DATA_W-1:0]        dt,
                              input logic [DATA_W-1:0]        rate);
        wait_idle();
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_DRIVE_MIN, lo);
        write_reg(REG_DRIVE_MAX, hi);
        write_reg(REG_STEP_TIME, dt);
        write_reg(REG_STEP_RATE, rate);
        write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // A measurement tracking a set point, full-range, small-range and edge samples.
    task automatic pick_item(output logic signed [DATA_W-1:0] t,
                             output logic signed [DATA_W-1:0] s);
        int noise;
        if ($urandom_range(0, 15) == 0)
            setpoint = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                noise = int'($urandom_range(0, 400)) - 200;
                t = setpoint;
                s = 16'(int'(setpoint) + noise);
            end
            4, 5, 6:
            begin
                t = 16'($urandom);
                s = 16'($urandom);
            end
            7, 8:
            begin
                t = 16'(int'($urandom_range(0, 511)) - 256);
                s = 16'(int'($urandom_range(0, 511)) - 256);
            end
            default:
            begin
                t = pick_extreme();
                s = pick_extreme();
            end
        endcase
    endtask

    // Random samples in bursts, separated by gaps, by a full drain or by no pause.
    task automatic run_random(input int count);
        int sent;
        int burst;
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] s;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < count; k++)
            begin
                pick_item(t, s);
                send_item(t, s);
                sent++;
            end
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            else if ($urandom_range(0, 3) != 0)
                idle_for($urandom_range(1, 17));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic signed [DATA_W-1:0] t;
        logic signed [DATA_W-1:0] s;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Limits and periods at their reset values, no integral term yet;
        // the first sample must carry no derivative.
        write_reg(REG_GAIN_P, 16'sd256);
        write_reg(REG_GAIN_D, 16'sd1);
        cfg_we <= 1'b0;
        n_settings++;
        send_item(16'sd100, 16'sd0);
        send_item(16'sd100, 16'sd0);
        send_item(-16'sd32768, 16'sd32767);
        send_item(16'sd32767, -16'sd32768);
        send_item(16'sd0, 16'sd0);
        send_item(-16'sd32768, -16'sd32768);
        send_item(16'sd32767, 16'sd32767);

        // Half gain: odd errors land exactly on rounding ties.
        set_config(16'sd128, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'd66, 16'd1000);
        send_item(16'sd1, 16'sd0);
        send_item(16'sd0, 16'sd1);
        send_item(16'sd3, 16'sd0);
        send_item(16'sd0, 16'sd3);
        send_item(16'sd2, 16'sd0);

        // Zero periods fall back to their defaults.
        set_config(16'sd0, 16'sd32767, 16'sd4, -16'sd32768, 16'sd32767, 16'd0, 16'd0);
        send_item(16'sd10, 16'sd0);
        send_item(16'sd20, 16'sd0);
        send_item(-16'sd5, 16'sd0);

        // Crossed limits: the high test wins and both flags can be set.
        set_config(16'sd256, 16'sd16, 16'sd0, 16'sd100, -16'sd100, 16'd66, 16'd1000);
        send_item(16'sd0, 16'sd0);
        send_item(16'sd200, 16'sd0);
        send_item(16'sd0, 16'sd200);
        send_item(16'sd1, 16'sd0);

        // Typical tuning; the output side holds off while samples keep coming.
        set_config(16'sd256, 16'sd64, 16'sd8, -16'sd32768, 16'sd32767, 16'd66, 16'd1000);
        hold_req = 1'b1;
        repeat (16)
        begin
            pick_item(t, s);
            send_item(t, s);
        end
        run_random(PHASE_ITEMS - 16);

        // Extreme gains and periods
        set_config(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                   16'd65535, 16'd65535);
        run_random(PHASE_ITEMS);
        set_config(-16'sd32768, 16'sd32767, -16'sd32768, -16'sd1000, 16'sd1000, 16'd1, 16'd1);
        run_random(PHASE_ITEMS);

        // Random gains with crossed limits, then everything random
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'sd50, -16'sd50,
                   16'($urandom), 16'($urandom));
        run_random(PHASE_ITEMS);
        set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
        run_random(PHASE_ITEMS);

        // Moderate random gains with zero periods
        set_config(16'(int'($urandom_range(0, 1023)) - 512),
                   16'(int'($urandom_range(0, 1023)) - 512),
                   16'(int'($urandom_range(0, 63)) - 32),
                   -16'sd2000, 16'sd3000, 16'd0, 16'd0);
        run_random(PHASE_ITEMS);

        // Build a large integral that reaches the top limb with all gains off,
        // then read it back through the integral gain.
        set_config(16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767, 16'd65535, 16'd1);
        repeat (WINDUP_ITEMS) send_item(16'sd32767, -16'sd32768);
        set_config(16'sd0, 16'sd1, 16'sd0, -16'sd32768, 16'sd32767, 16'd65535, 16'd1);
        send_item(16'sd32767, -16'sd32768);
        send_item(-16'sd32768, 16'sd32767);
        send_item(16'sd0, 16'sd0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d sample transfers and %0d result transfers over %0d settings,",
                 n_items, results_seen, n_settings);
        $display("including rounding ties, crossed limits, zero periods and a large integral.");
        if (backlog != 0)
            $display("%0d expected results never arrived", backlog);
        if (fail_count == 0 && backlog == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[sim.f]
src/pcaw_pkg.sv
src/pcaw_cfg.sv
src/pcaw_mul.sv
src/pid_controller_clamp_antiwindup.sv
tb/pcaw_checker.sv
tb/tb.sv
